// File: hdl/lsc_pkg.sv
package lsc_pkg;

  localparam int COUNT_W = 16;
  localparam int LUX_W   = 32;
  localparam int IRF_W   = 17;
  localparam int IAC_W   = 30;
  localparam int ACC_W   = 32;
  localparam int PROD_W  = 39;
  localparam int DEN_W   = 29;
  localparam int COEF_W  = 15;
  localparam int ITER_W  = 6;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;
  localparam int IRF_PAD = PROD_W - IAC_W - 2;

  localparam logic [ITER_W-1:0] LUX_ITERS = ITER_W'(PROD_W);
  localparam logic [ITER_W-1:0] IRF_ITERS = ITER_W'(LUX_W);

  localparam logic [COEF_W-1:0] COEF_B     = 15'd26870;
  localparam logic [COEF_W-1:0] COEF_C     = 15'd9667;
  localparam logic [COEF_W-1:0] COEF_D     = 15'd14090;
  localparam logic [COEF_W-1:0] DEV_FACTOR = 15'd408;

  localparam logic [COUNT_W-1:0] SAT_LONG  = 16'd65535;
  localparam logic [COUNT_W-1:0] SAT_SHORT = 16'd36863;
  localparam logic [COUNT_W-1:0] RIP_LONG  = 16'd49151;
  localparam logic [COUNT_W-1:0] RIP_SHORT = 16'd27647;

  localparam logic [2:0] INTEG_MAX   = 3'd5;
  localparam logic [1:0] GAIN_RESET  = 2'd1;
  localparam logic [2:0] INTEG_RESET = 3'd0;

  localparam logic REG_GAIN  = 1'b0;
  localparam logic REG_INTEG = 1'b1;

  // Divisor time_ms * gain * 64, rows by gain select, columns by integration time.
  localparam logic [DEN_W-1:0] DEN_TAB [4][6] = '{
    '{29'd6400, 29'd12800, 29'd19200, 29'd25600, 29'd32000, 29'd38400},
    '{29'd160000, 29'd320000, 29'd480000, 29'd640000, 29'd800000, 29'd960000},
    '{29'd2560000, 29'd5120000, 29'd7680000, 29'd10240000, 29'd12800000,
      29'd15360000},
    '{29'd58880000, 29'd117760000, 29'd176640000, 29'd235520000, 29'd294400000,
      29'd353280000}
  };

  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] iters;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  function automatic logic [2:0] integ_clamp(input logic [2:0] idx);
    integ_clamp = (idx > INTEG_MAX) ? INTEG_MAX : idx;
  endfunction

  function automatic logic [DEN_W-1:0] den_lookup(input logic [1:0] gain,
                                                  input logic [2:0] integ);
    den_lookup = DEN_TAB[gain][integ_clamp(integ)];
  endfunction

endpackage

// File: hdl/lsc_if.sv
interface lsc_in_if;
  logic                           valid;
  logic                           ready;
  logic [lsc_pkg::COUNT_W-1:0]    full_count;
  logic [lsc_pkg::COUNT_W-1:0]    ir_count;

  modport source (output valid, full_count, ir_count, input ready);
  modport sink (input valid, full_count, ir_count, output ready);
endinterface

interface lsc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         status;
  logic                         saturated;
  logic                         ripple_saturated;
  logic [lsc_pkg::LUX_W-1:0]    lux_q8;
  logic [lsc_pkg::IRF_W-1:0]    ir_factor_q16;

  modport source (output valid, status, saturated, ripple_saturated, lux_q8,
                  ir_factor_q16, input ready);
  modport sink (input valid, status, saturated, ripple_saturated, lux_q8,
                ir_factor_q16, output ready);
endinterface

// File: hdl/lsc_div.sv
module lsc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lsc_pkg::div_cmd_t             cmd,
  input  logic [lsc_pkg::PROD_W-1:0]    dividend,
  input  logic [lsc_pkg::DEN_W-1:0]     divisor,
  output lsc_pkg::div_sts_t             sts,
  output logic [lsc_pkg::LUX_W-1:0]     quotient
);
  import lsc_pkg::*;

  logic [PROD_W-1:0] dvd_r, dvd_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  dsr_r, dsr_nxt;
  logic [ITER_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DEN_W:0]    shifted;
  logic [DEN_W+1:0]  diff;
  logic              qbit;

  assign shifted = {rem_r, dvd_r[PROD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_r};
  assign qbit    = ~diff[DEN_W+1];

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = cmd.iters;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[PROD_W-2:0], qbit};
      rem_nxt = qbit ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == ITER_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = dvd_r[LUX_W-1:0];

endmodule

// File: hdl/light_sensor_lux_calc.sv
// Channel    Direction  Carries
// in_chan    sink       full_count, ir_count
// out_chan   source     status, saturated, ripple_saturated, lux_q8, ir_factor_q16
// cfg_*      APB slave  gain_index at 0x0, integ_index at 0x4
//
// An item that overflows skips the arithmetic and is loaded into the output
// register once it is free. A zero full count skips the IR factor division.
// Any other item passes through one shared multiplier used four times and one
// restoring divider that runs 39 steps for lux and 32 steps for the IR factor.
// A new item is accepted once the previous result has moved to the output register.
// Reset is synchronous and clears control state, the held lux and the held IR factor.
module light_sensor_lux_calc (
  input  logic                          clk,
  input  logic                          rst_n,
  lsc_in_if.sink                        in_chan,
  lsc_out_if.source                     out_chan,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [lsc_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [lsc_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [lsc_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import lsc_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_MUL_B    = 12'b000000000010,
    S_MUL_C    = 12'b000000000100,
    S_MUL_D    = 12'b000000001000,
    S_SUB      = 12'b000000010000,
    S_MAX      = 12'b000000100000,
    S_SCALE    = 12'b000001000000,
    S_LUX_GO   = 12'b000010000000,
    S_LUX_WAIT = 12'b000100000000,
    S_IRF_GO   = 12'b001000000000,
    S_IRF_WAIT = 12'b010000000000,
    S_FIN      = 12'b100000000000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [1:0]               gain_r;
  logic [2:0]               integ_r;
  logic [COUNT_W-1:0]       full_r, full_nxt;
  logic [COUNT_W-1:0]       ir_r, ir_nxt;
  logic                     ovf_r, ovf_nxt;
  logic                     rip_r, rip_nxt;
  logic [PROD_W-1:0]        prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc1_r, acc1_nxt;
  logic signed [ACC_W-1:0]  acc2_r, acc2_nxt;
  logic signed [ACC_W-1:0]  pick;
  logic [IAC_W-1:0]         iac_r, iac_nxt;
  logic [LUX_W-1:0]         held_lux_r, held_lux_nxt;
  logic [IRF_W-1:0]         held_irf_r, held_irf_nxt;
  logic                     out_valid_r;
  logic                     out_status_r;
  logic                     out_sat_r;
  logic                     out_rip_r;
  logic [LUX_W-1:0]         out_lux_r;
  logic [IRF_W-1:0]         out_irf_r;
  logic                     out_load;
  logic                     long_time;
  logic [COUNT_W-1:0]       sat_lvl;
  logic [COUNT_W-1:0]       rip_lvl;
  logic                     in_ovf;
  logic                     in_rip;
  logic [IAC_W-1:0]         mul_a;
  logic [COEF_W-1:0]        mul_b;
  logic                     mul_en;
  logic [PROD_W-1:0]        mul_p;
  div_cmd_t                 div_cmd;
  div_sts_t                 div_sts;
  logic [PROD_W-1:0]        div_dvd;
  logic [DEN_W-1:0]         div_dsr;
  logic [LUX_W-1:0]         div_q;
  logic                     cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_INTEG) ? CFG_DW'(integ_r) : CFG_DW'(gain_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= GAIN_RESET;
      integ_r <= INTEG_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_GAIN:  gain_r  <= cfg_pwdata[1:0];
        REG_INTEG: integ_r <= cfg_pwdata[2:0];
        default: begin
        end
      endcase
    end
  end

  // Every integration time from 200 ms up lies above the long-time threshold.
  assign long_time = (integ_clamp(integ_r) != INTEG_RESET);
  assign sat_lvl   = long_time ? SAT_LONG : SAT_SHORT;
  assign rip_lvl   = long_time ? RIP_LONG : RIP_SHORT;
  assign in_ovf    = (in_chan.full_count >= sat_lvl) || (in_chan.ir_count >= sat_lvl);
  assign in_rip    = (in_chan.full_count >= rip_lvl) || (in_chan.ir_count >= rip_lvl);

  assign mul_p    = {{(PROD_W-IAC_W){1'b0}}, mul_a} * {{(PROD_W-COEF_W){1'b0}}, mul_b};
  assign pick     = (acc1_r > acc2_r) ? acc1_r : acc2_r;
  assign in_chan.ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt    = state_r;
    full_nxt     = full_r;
    ir_nxt       = ir_r;
    ovf_nxt      = ovf_r;
    rip_nxt      = rip_r;
    acc1_nxt     = acc1_r;
    acc2_nxt     = acc2_r;
    iac_nxt      = iac_r;
    held_lux_nxt = held_lux_r;
    held_irf_nxt = held_irf_r;
    mul_a        = '0;
    mul_b        = '0;
    mul_en       = 1'b0;
    div_cmd      = '0;
    div_dvd      = '0;
    div_dsr      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          full_nxt  = in_chan.full_count;
          ir_nxt    = in_chan.ir_count;
          ovf_nxt   = in_ovf;
          rip_nxt   = in_rip;
          state_nxt = in_ovf ? S_FIN : S_MUL_B;
        end
      end
      S_MUL_B: begin
        mul_a     = IAC_W'(ir_r);
        mul_b     = COEF_B;
        mul_en    = 1'b1;
        state_nxt = S_MUL_C;
      end
      S_MUL_C: begin
        acc1_nxt  = $signed({2'b00, full_r, 14'd0}) - $signed({1'b0, prod_r[ACC_W-2:0]});
        mul_a     = IAC_W'(full_r);
        mul_b     = COEF_C;
        mul_en    = 1'b1;
        state_nxt = S_MUL_D;
      end
      S_MUL_D: begin
        acc2_nxt  = $signed({1'b0, prod_r[ACC_W-2:0]});
        mul_a     = IAC_W'(ir_r);
        mul_b     = COEF_D;
        mul_en    = 1'b1;
        state_nxt = S_SUB;
      end
      S_SUB: begin
        acc2_nxt  = acc2_r - $signed({1'b0, prod_r[ACC_W-2:0]});
        state_nxt = S_MAX;
      end
      S_MAX: begin
        iac_nxt   = pick[ACC_W-1] ? '0 : pick[IAC_W-1:0];
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        mul_a     = iac_r;
        mul_b     = DEV_FACTOR;
        mul_en    = 1'b1;
        state_nxt = S_LUX_GO;
      end
      S_LUX_GO: begin
        div_cmd.start = 1'b1;
        div_cmd.iters = LUX_ITERS;
        div_dvd       = prod_r;
        div_dsr       = den_lookup(gain_r, integ_r);
        state_nxt     = S_LUX_WAIT;
      end
      S_LUX_WAIT: begin
        if (div_sts.done) begin
          held_lux_nxt = div_q;
          state_nxt    = S_IRF_GO;
        end
      end
      S_IRF_GO: begin
        if (full_r == '0) begin
          held_irf_nxt = '0;
          state_nxt    = S_FIN;
        end else begin
          div_cmd.start = 1'b1;
          div_cmd.iters = IRF_ITERS;
          div_dvd       = {iac_r, 2'b00, {IRF_PAD{1'b0}}};
          div_dsr       = DEN_W'(full_r);
          state_nxt     = S_IRF_WAIT;
        end
      end
      S_IRF_WAIT: begin
        if (div_sts.done) begin
          held_irf_nxt = div_q[IRF_W-1:0];
          state_nxt    = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign prod_nxt = mul_en ? mul_p : prod_r;

  lsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (div_cmd),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .sts      (div_sts),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    full_r <= full_nxt;
    ir_r   <= ir_nxt;
    ovf_r  <= ovf_nxt;
    rip_r  <= rip_nxt;
    prod_r <= prod_nxt;
    acc1_r <= acc1_nxt;
    acc2_r <= acc2_nxt;
    iac_r  <= iac_nxt;
    if (out_load) begin
      out_status_r <= ovf_r;
      out_sat_r    <= ovf_r;
      out_rip_r    <= rip_r;
      out_lux_r    <= held_lux_r;
      out_irf_r    <= held_irf_r;
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_lux_r  <= '0;
      held_irf_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      held_lux_r <= held_lux_nxt;
      held_irf_r <= held_irf_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.status           = out_status_r;
  assign out_chan.saturated        = out_sat_r;
  assign out_chan.ripple_saturated = out_rip_r;
  assign out_chan.lux_q8           = out_lux_r;
  assign out_chan.ir_factor_q16    = out_irf_r;

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_cmd.start |-> !div_sts.busy)
    else $error("divider started while busy");

  a_ovf_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> (out_sat_r && out_rip_r))
    else $error("overflow result without saturation flags");

  a_irf_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_irf_r <= 17'd65536))
    else $error("IR factor above one");

  a_held_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |=> ($stable(held_lux_r) && $stable(held_irf_r)))
    else $error("held values changed on item acceptance");

endmodule

// File: bench/tb_light_sensor_lux_calc.sv
`timescale 1ns / 1ps

module tb_light_sensor_lux_calc;
  import lsc_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RST_CYCLES   = 5;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 400;
  localparam int PRESS_ITEMS  = 30;
  localparam int PHASE_N      = 12;
  localparam int PHASE_ITEMS  = 108;
  localparam int LISTED_N     = 9;
  localparam int DIR_N        = 25;

  localparam logic [CFG_AW-1:0] ADDR_GAIN  = {REG_GAIN, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_INTEG = {REG_INTEG, 2'b00};

  localparam logic ST_OK       = 1'b0;
  localparam logic ST_OVERFLOW = 1'b1;

  localparam logic [1:0] GAIN_AT_RESET  = 2'd1;
  localparam logic [2:0] INTEG_AT_RESET = 3'd0;
  localparam logic [2:0] INTEG_TOP      = 3'd5;

  localparam longint Q14_ONE   = 16384;
  localparam longint K_IR_A    = 26870;
  localparam longint K_FULL_B  = 9667;
  localparam longint K_IR_B    = 14090;
  localparam longint LUX_SCALE = 408;
  localparam int unsigned LONG_MS    = 172;
  localparam int unsigned SAT_AT_LONG  = 65535;
  localparam int unsigned SAT_AT_SHORT = 36863;
  localparam int unsigned COUNT_TOP    = 65535;

  localparam int unsigned MS_TAB [6]   = '{100, 200, 300, 400, 500, 600};
  localparam int unsigned GAIN_TAB [4] = '{1, 25, 400, 9200};

  localparam logic [1:0] PH_GAIN [LISTED_N]  = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1,
                                                 2'd2, 2'd0};
  localparam logic [2:0] PH_INTEG [LISTED_N] = '{3'd0, 3'd5, 3'd0, 3'd1, 3'd7, 3'd6, 3'd2,
                                                 3'd4, 3'd3};

  typedef struct packed {
    logic             status;
    logic             saturated;
    logic             ripple_saturated;
    logic [LUX_W-1:0] lux_q8;
    logic [IRF_W-1:0] ir_factor_q16;
  } lux_res_t;

  typedef struct packed {
    logic [1:0]         gain;
    logic [2:0]         integ;
    logic [COUNT_W-1:0] full;
    logic [COUNT_W-1:0] ir;
    logic               pinned;
    lux_res_t           res;
  } lux_row_t;

  localparam lux_res_t NO_PIN = '0;

  // Rows with a typed result are read straight off the definition; the rest use the predictor.
  localparam lux_row_t DIR_TAB [DIR_N] = '{
    '{2'd1, 3'd0, 16'd65535, 16'd0,     1'b1, '{ST_OVERFLOW, 1'b1, 1'b1, 32'd0, 17'd0}},
    '{2'd1, 3'd0, 16'd0,     16'd0,     1'b1, '{ST_OK, 1'b0, 1'b0, 32'd0, 17'd0}},
    '{2'd1, 3'd0, 16'd0,     16'd65535, 1'b1, '{ST_OVERFLOW, 1'b1, 1'b1, 32'd0, 17'd0}},
    '{2'd1, 3'd0, 16'd36863, 16'd0,     1'b1, '{ST_OVERFLOW, 1'b1, 1'b1, 32'd0, 17'd0}},
    '{2'd1, 3'd0, 16'd36862, 16'd0,     1'b0, NO_PIN},
    '{2'd1, 3'd0, 16'd27647, 16'd0,     1'b0, NO_PIN},
    '{2'd1, 3'd0, 16'd27646, 16'd27646, 1'b1, '{ST_OK, 1'b0, 1'b0, 32'd0, 17'd0}},
    '{2'd1, 3'd0, 16'd0,     16'd27647, 1'b1, '{ST_OK, 1'b0, 1'b1, 32'd0, 17'd0}},
    '{2'd1, 3'd0, 16'd100,   16'd36863, 1'b0, NO_PIN},
    '{2'd0, 3'd0, 16'd36862, 16'd0,     1'b0, NO_PIN},
    '{2'd0, 3'd0, 16'd1,     16'd0,     1'b1, '{ST_OK, 1'b0, 1'b0, 32'd1044, 17'd65536}},
    '{2'd0, 3'd0, 16'd36862, 16'd36862, 1'b0, NO_PIN},
    '{2'd0, 3'd1, 16'd65534, 16'd0,     1'b0, NO_PIN},
    '{2'd0, 3'd1, 16'd65535, 16'd0,     1'b0, NO_PIN},
    '{2'd0, 3'd1, 16'd49151, 16'd0,     1'b0, NO_PIN},
    '{2'd0, 3'd1, 16'd49150, 16'd100,   1'b0, NO_PIN},
    '{2'd3, 3'd5, 16'd65534, 16'd65534, 1'b0, NO_PIN},
    '{2'd3, 3'd5, 16'd65534, 16'd1,     1'b0, NO_PIN},
    '{2'd3, 3'd6, 16'd40000, 16'd5000,  1'b0, NO_PIN},
    '{2'd3, 3'd7, 16'd1000,  16'd300,   1'b0, NO_PIN},
    '{2'd2, 3'd2, 16'd30000, 16'd10000, 1'b0, NO_PIN},
    '{2'd2, 3'd7, 16'd0,     16'd0,     1'b1, '{ST_OK, 1'b0, 1'b0, 32'd0, 17'd0}},
    '{2'd1, 3'd1, 16'd12345, 16'd54321, 1'b1, '{ST_OK, 1'b0, 1'b1, 32'd0, 17'd0}},
    '{2'd2, 3'd3, 16'd65535, 16'd65535, 1'b1, '{ST_OVERFLOW, 1'b1, 1'b1, 32'd0, 17'd0}},
    '{2'd1, 3'd0, 16'd20000, 16'd4000,  1'b0, NO_PIN}
  };

  logic clk;
  logic rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  lsc_in_if  in_if ();
  lsc_out_if out_if ();

  light_sensor_lux_calc i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_if),
    .out_chan    (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  logic [1:0]       m_gain      = GAIN_AT_RESET;
  logic [2:0]       m_integ     = INTEG_AT_RESET;
  logic [LUX_W-1:0] m_held_lux  = '0;
  logic [IRF_W-1:0] m_held_irf  = '0;

  logic [1:0] cur_gain  = GAIN_AT_RESET;
  logic [2:0] cur_integ = INTEG_AT_RESET;

  lux_res_t lux_expq [$];
  logic     drv_pinned;
  lux_res_t drv_pin_res;

  int errors   = 0;
  int cycles   = 0;
  int n_items  = 0;
  int n_held   = 0;
  int n_ripple = 0;
  int n_cfg    = 0;
  int hold_req = 0;
  bit in_idle  = 1'b1;
  bit out_idle = 1'b1;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int unsigned integ_ms(input logic [2:0] integ);
    return MS_TAB[(integ > INTEG_TOP) ? INTEG_TOP : integ];
  endfunction

  function automatic int unsigned sat_level(input logic [2:0] integ);
    return (integ_ms(integ) > LONG_MS) ? SAT_AT_LONG : SAT_AT_SHORT;
  endfunction

  // Works out the result of one reading and, unless it overflows, updates the held lux and IR factor.
  function automatic lux_res_t lux_predict(input logic [COUNT_W-1:0] full,
                                           input logic [COUNT_W-1:0] ir);
    longint f, r, iac1, iac2, iac, den, lux, irf;
    int unsigned sat, rip;
    lux_res_t res;
    sat = sat_level(m_integ);
    rip = (sat * 3) >> 2;
    if (full >= sat || ir >= sat) begin
      res.status           = ST_OVERFLOW;
      res.saturated        = 1'b1;
      res.ripple_saturated = 1'b1;
      res.lux_q8           = m_held_lux;
      res.ir_factor_q16    = m_held_irf;
      return res;
    end
    f    = full;
    r    = ir;
    iac1 = f * Q14_ONE - K_IR_A * r;
    iac2 = K_FULL_B * f - K_IR_B * r;
    iac  = 0;
    if (iac1 > iac) iac = iac1;
    if (iac2 > iac) iac = iac2;
    den = longint'(integ_ms(m_integ)) * longint'(GAIN_TAB[m_gain]) * 64;
    lux = (iac * LUX_SCALE) / den;
    irf = (full != 0) ? (iac * 4) / f : 0;
    m_held_lux           = LUX_W'(lux);
    m_held_irf           = IRF_W'(irf);
    res.status           = ST_OK;
    res.saturated        = 1'b0;
    res.ripple_saturated = (full >= rip || ir >= rip);
    res.lux_q8           = m_held_lux;
    res.ir_factor_q16    = m_held_irf;
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    lux_res_t pred;
    lux_res_t want;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else if (rst_n) begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr)
          ADDR_GAIN:  m_gain = cfg_pwdata[1:0];
          ADDR_INTEG: m_integ = cfg_pwdata[2:0];
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        if (lux_expq.size() == 0) begin
          $error("result with no item outstanding");
          errors++;
        end else begin
          want = lux_expq.pop_front();
          if (want.status == ST_OVERFLOW) n_held++;
          if (want.ripple_saturated) n_ripple++;
          if (out_if.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_if.status);
            errors++;
          end
          if (out_if.saturated !== want.saturated) begin
            $error("saturated: expected %0d, actual %0d", want.saturated, out_if.saturated);
            errors++;
          end
          if (out_if.ripple_saturated !== want.ripple_saturated) begin
            $error("ripple_saturated: expected %0d, actual %0d", want.ripple_saturated,
                   out_if.ripple_saturated);
            errors++;
          end
          if (out_if.lux_q8 !== want.lux_q8) begin
            $error("lux_q8: expected %0d, actual %0d", want.lux_q8, out_if.lux_q8);
            errors++;
          end
          if (out_if.ir_factor_q16 !== want.ir_factor_q16) begin
            $error("ir_factor_q16: expected %0d, actual %0d", want.ir_factor_q16,
                   out_if.ir_factor_q16);
            errors++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        pred = lux_predict(in_if.full_count, in_if.ir_count);
        lux_expq.push_back(drv_pinned ? drv_pin_res : pred);
        n_items++;
      end
    end
  end

  initial begin : receiver
    int n;
    bit hold_taken;
    hold_taken   = 1'b0;
    out_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      n = (hold_req > 0 && !hold_taken) ? hold_req : (out_idle ? $urandom_range(0, 8) : 0);
      if (hold_req > 0) hold_taken = 1'b1;
      if (n > 0) begin
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (lux_expq.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_sensor_mode(input logic [1:0] gain, input logic [2:0] integ);
    drain_results();
    cfg_write(ADDR_GAIN, ($urandom() & ~32'h3) | gain);
    cfg_write(ADDR_INTEG, ($urandom() & ~32'h7) | integ);
    cur_gain  = gain;
    cur_integ = integ;
    n_cfg++;
  endtask

  task automatic send_reading(input logic [COUNT_W-1:0] full, input logic [COUNT_W-1:0] ir,
                              input logic pinned, input lux_res_t res);
    int gap;
    gap = in_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.full_count <= full;
    in_if.ir_count   <= ir;
    drv_pinned       <= pinned;
    drv_pin_res      <= res;
    do @(posedge clk); while (!in_if.ready);
  endtask

  function automatic logic [COUNT_W-1:0] pick_count(input int unsigned sat);
    int unsigned v;
    case ($urandom_range(0, 7))
      0: v = $urandom_range(0, COUNT_TOP);
      1: v = sat - 2 + $urandom_range(0, 4);
      2: v = ((sat * 3) >> 2) - 2 + $urandom_range(0, 4);
      3: v = $urandom_range(0, 15);
      default: v = $urandom_range(0, sat - 1);
    endcase
    if (v > COUNT_TOP) v = COUNT_TOP;
    return COUNT_W'(v);
  endfunction

  initial begin : stimulus
    logic [COUNT_W-1:0] full, ir;
    logic [1:0] gain;
    logic [2:0] integ;
    int unsigned sat;
    rst_n            = 1'b0;
    in_if.valid      <= 1'b0;
    in_if.full_count <= '0;
    in_if.ir_count   <= '0;
    cfg_psel         <= 1'b0;
    cfg_penable      <= 1'b0;
    cfg_pwrite       <= 1'b0;
    cfg_paddr        <= '0;
    cfg_pwdata       <= '0;
    drv_pinned       <= 1'b0;
    drv_pin_res      <= NO_PIN;
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_TAB[i].gain != cur_gain || DIR_TAB[i].integ != cur_integ)
        set_sensor_mode(DIR_TAB[i].gain, DIR_TAB[i].integ);
      send_reading(DIR_TAB[i].full, DIR_TAB[i].ir, DIR_TAB[i].pinned, DIR_TAB[i].res);
    end

    for (int p = 0; p < PHASE_N; p++) begin
      if (p < LISTED_N) begin
        gain  = PH_GAIN[p];
        integ = PH_INTEG[p];
      end else begin
        gain  = $urandom_range(0, 3);
        integ = $urandom_range(0, 7);
      end
      set_sensor_mode(gain, integ);
      sat      = sat_level(cur_integ);
      in_idle  = (p % 4 != 1);
      out_idle = (p % 4 != 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Stall the output for a long stretch while readings arrive back to back.
        if (p == 3 && k == 0) begin
          hold_req = HOLD_CYCLES;
          in_idle  = 1'b0;
        end
        if (p == 3 && k == PRESS_ITEMS) in_idle = 1'b1;
        if (k % 40 == 39 && $urandom_range(0, 2) == 0) drain_results();
        full = pick_count(sat);
        if ($urandom_range(0, 3) == 0) ir = pick_count(sat);
        else ir = COUNT_W'((int'(full) * $urandom_range(0, 100)) / 100);
        send_reading(full, ir, 1'b0, NO_PIN);
      end
    end

    drain_results();
    $display("Checked %0d readings over %0d sensor settings: %0d overflow, %0d ripple.",
             n_items, n_cfg, n_held, n_ripple);
    $display("Runs mixed idle gaps, back-to-back traffic, one long output stall and drains.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/lsc_pkg.sv
hdl/lsc_if.sv
hdl/lsc_div.sv
hdl/light_sensor_lux_calc.sv
bench/tb_light_sensor_lux_calc.sv
